// ===== hdl/sbic_pkg.sv =====
`default_nettype none
package sbic_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DIR_BITS  = 30;
   localparam int DT_BITS   = 16;

   typedef enum logic [2:0] {
      CMD_SET_POS   = 3'd0,
      CMD_SET_VEL   = 3'd1,
      CMD_ADD_ACC   = 3'd2,
      CMD_INTEGRATE = 3'd3,
      CMD_COLLIDE   = 3'd4
   } cmd_type;

   localparam logic CSR_MASS   = 1'b0;
   localparam logic CSR_RADIUS = 1'b1;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] other_vel_x;
      logic signed [31:0] other_vel_y;
      logic signed [31:0] other_vel_z;
      logic [31:0]        other_mass;
      logic [30:0]        other_radius;
      logic [15:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic               hit;
      logic signed [31:0] other_dv_x;
      logic signed [31:0] other_dv_y;
      logic signed [31:0] other_dv_z;
   } rsp_type;

   // serial multiplier request and result
   typedef struct packed {
      logic               start;
      logic signed [63:0] a;
      logic [31:0]        b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [95:0] p;
   } mul_rsp_type;

   // serial divider / square root request and result
   typedef struct packed {
      logic        start;
      logic        sqrt;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] q;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [97:0] x);
      if (x > 98'sd2147483647) return 32'sh7fffffff;
      if (x < -98'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/sbic_mul.sv =====
`default_nettype none
// shift-add multiplier, one multiplier bit per cycle
module sbic_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sbic_pkg::mul_req_type req,
   output sbic_pkg::mul_rsp_type    rsp
);
   import sbic_pkg::*;

   logic               busy_ff, busy_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [95:0] acc_ff, acc_in;
   logic signed [95:0] mcand_ff, mcand_in;
   logic [31:0]        mplier_ff, mplier_in;
   logic               done_ff, done_in;

   // one partial product per cycle, multiplicand shifts up
   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      done_in   = 1'b0;
      if (req.start) begin
         busy_in   = 1'b1;
         cnt_in    = 6'd0;
         acc_in    = '0;
         mcand_in  = 96'(req.a);
         mplier_in = req.b;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign rsp.done = done_ff;
   assign rsp.p    = acc_ff;
endmodule
`default_nettype wire

// ===== hdl/sbic_div.sv =====
`default_nettype none
// restoring divider and square root, one quotient bit per cycle
module sbic_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sbic_pkg::div_req_type req,
   output sbic_pkg::div_rsp_type    rsp
);
   import sbic_pkg::*;

   logic         busy_ff, busy_in;
   logic         sqrt_ff, sqrt_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [63:0]  num_ff, num_in;
   logic [63:0]  den_ff, den_in;
   logic [65:0]  rem_ff, rem_in;
   logic [63:0]  q_ff, q_in;
   logic         done_ff, done_in;
   logic [65:0]  rem_sh;
   logic [65:0]  trial;

   // divide: shift one numerator bit in; root: two bits against 4q+1
   always_comb begin
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      if (sqrt_ff) begin
         rem_sh = {rem_ff[63:0], num_ff[63:62]};
         trial  = {q_ff, 2'b01};
      end else begin
         rem_sh = {rem_ff[64:0], num_ff[63]};
         trial  = {2'b00, den_ff};
      end
      if (req.start) begin
         busy_in = 1'b1;
         sqrt_in = req.sqrt;
         cnt_in  = '0;
         num_in  = req.num;
         den_in  = req.den;
         rem_in  = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         num_in = sqrt_ff ? {num_ff[61:0], 2'b00} : {num_ff[62:0], 1'b0};
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if ((sqrt_ff && cnt_ff == 7'd31) || cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         sqrt_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         sqrt_ff <= sqrt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign rsp.done = done_ff;
   assign rsp.q    = q_ff;
endmodule
`default_nettype wire

// ===== hdl/sphere_body_integrate_collide_core.sv =====
`default_nettype none
// One sphere body in signed Q16.16: commands set position or velocity, add
// acceleration, integrate by dt, or collide with another body. One result beat
// per command. Integrate runs nine serial multiplies; collide runs its products,
// and on contact three square roots and up to five divisions, through one
// shared bit-serial multiplier and one bit-serial divider/root unit. The next
// command is taken once the result register is free and the sequencer is back
// at rest.
module sphere_body_integrate_collide_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sbic_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sbic_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [31:0]       csr_data
);
   import sbic_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INT_MUL, ST_INT_WAIT, ST_COL_D, ST_COL_SQ, ST_COL_SQW,
      ST_COL_LEN, ST_COL_LENW, ST_COL_DIR, ST_COL_DIRW, ST_COL_PEN, ST_COL_PENW,
      ST_COL_MAG, ST_COL_MAGW, ST_COL_RT, ST_COL_RTW, ST_COL_FR, ST_COL_FRW,
      ST_COL_K, ST_COL_KW, ST_COL_V, ST_COL_VW, ST_DONE
   } state_type;

   state_type          state_ff;
   logic [31:0]        mass_ff;
   logic [30:0]        radius_ff;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] acc_ff [3];
   req_type            cur_ff;
   rsp_type            out_ff;
   logic               out_valid_ff;
   logic [3:0]         idx_ff;
   logic signed [33:0] d_ff [3];
   logic [63:0]        d2_ff;
   logic [63:0]        len_ff;
   logic signed [31:0] dir_ff [3];
   logic [63:0]        root_ff [2];
   logic [31:0]        fa_ff, fb_ff;
   logic signed [95:0] k_ff [2];
   logic signed [31:0] odv_ff [3];
   logic signed [31:0] tmp_ff [3];
   logic               hit_ff;

   mul_req_type mreq;
   mul_rsp_type mrsp;
   div_req_type dreq;
   div_rsp_type drsp;

   sbic_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));
   sbic_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [31:0] rsum;
   logic [1:0]  i2;
   logic [33:0] dabs;
   logic [63:0] msum;
   logic [1:0]  v3;

   assign rsum      = {1'b0, radius_ff} + {1'b0, cur_ff.other_radius};
   assign msum      = 64'(mass_ff) + 64'(cur_ff.other_mass);
   assign i2        = idx_ff[1:0];
   assign dabs      = d_ff[i2][33] ? 34'(-d_ff[i2]) : d_ff[i2];
   assign v3        = (idx_ff < 4'd3) ? idx_ff[1:0] : 2'(idx_ff - 4'd3);
   assign req_ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   function automatic logic signed [31:0] ovel(input req_type r, input logic [1:0] k);
      case (k)
         2'd0:    return r.other_vel_x;
         2'd1:    return r.other_vel_y;
         default: return r.other_vel_z;
      endcase
   endfunction

   function automatic logic signed [31:0] ovec(input req_type r, input logic [1:0] k);
      case (k)
         2'd0:    return r.vec_x;
         2'd1:    return r.vec_y;
         default: return r.vec_z;
      endcase
   endfunction

   // shared unit requests, issued from the launching states
   always_comb begin
      mreq = '0;
      dreq = '0;
      unique case (state_ff)
         ST_INT_MUL: begin
            mreq.start = 1'b1;
            unique case (idx_ff)
               4'd0, 4'd1, 4'd2: begin
                  mreq.a = 64'(vel_ff[i2]);
                  mreq.b = 32'(cur_ff.time_step);
               end
               4'd3, 4'd4, 4'd5: begin
                  mreq.a = 64'(acc_ff[v3]);
                  mreq.b = 32'(cur_ff.time_step);
               end
               default: begin
                  mreq.a = 64'(acc_ff[2'(idx_ff - 4'd6)]);
                  mreq.b = 32'(cur_ff.time_step) * 32'(cur_ff.time_step);
               end
            endcase
         end
         ST_COL_SQ: begin
            mreq.start = 1'b1;
            mreq.a     = 64'(dabs);
            mreq.b     = dabs[31:0];
         end
         ST_COL_MAG: begin
            mreq.start = 1'b1;
            mreq.a     = (idx_ff < 4'd3) ? 64'(ovel(cur_ff, i2)) : 64'(vel_ff[v3]);
            mreq.b     = (idx_ff < 4'd3) ? ovel(cur_ff, i2) : vel_ff[v3];
            if (mreq.a[63]) mreq.a = -mreq.a;
            if (mreq.b[31]) mreq.b = -mreq.b;
         end
         ST_COL_PEN: begin
            mreq.start = 1'b1;
            mreq.a     = 64'(dir_ff[i2]);
            mreq.b     = rsum - len_ff[31:0];
         end
         ST_COL_K: begin
            mreq.start = 1'b1;
            mreq.a     = 64'(signed'(root_ff[0]) - signed'(root_ff[1])) <<< 1;
            mreq.b     = idx_ff[0] ? fb_ff : fa_ff;
         end
         ST_COL_V: begin
            mreq.start = 1'b1;
            mreq.a     = 64'(k_ff[idx_ff >= 4'd3] >>> DIR_BITS);
            mreq.b     = dir_ff[v3];
            // b is taken unsigned: move the normal's sign over to a
            if (mreq.b[31]) begin
               mreq.a = -mreq.a;
               mreq.b = -mreq.b;
            end
         end
         ST_COL_LEN: begin
            dreq.start = 1'b1;
            dreq.sqrt  = 1'b1;
            dreq.num   = d2_ff;
         end
         ST_COL_RT: begin
            dreq.start = 1'b1;
            dreq.sqrt  = 1'b1;
            dreq.num   = root_ff[idx_ff[0]];
         end
         ST_COL_DIR: begin
            dreq.start = 1'b1;
            dreq.num   = 64'(dabs) << DIR_BITS;
            dreq.den   = len_ff;
         end
         ST_COL_FR: begin
            dreq.start = 1'b1;
            dreq.num   = 64'(idx_ff[0] ? mass_ff : cur_ff.other_mass) << DIR_BITS;
            dreq.den   = msum;
         end
         default: ;
      endcase
   end

   // sequencer and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         mass_ff      <= 32'd65536;
         radius_ff    <= 31'd65536;
         for (int k = 0; k < 3; k++) begin
            pos_ff[k] <= '0;
            vel_ff[k] <= '0;
            acc_ff[k] <= '0;
         end
         idx_ff <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_MASS) mass_ff <= csr_data;
            else radius_ff <= csr_data[30:0];
         end
         if (out_valid_ff && rsp_ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  cur_ff <= req_data;
                  hit_ff <= 1'b0;
                  idx_ff <= '0;
                  for (int k = 0; k < 3; k++) odv_ff[k] <= '0;
                  case (req_data.cmd)
                     CMD_SET_POS: begin
                        pos_ff[0] <= req_data.vec_x;
                        pos_ff[1] <= req_data.vec_y;
                        pos_ff[2] <= req_data.vec_z;
                        state_ff  <= ST_DONE;
                     end
                     CMD_SET_VEL: begin
                        vel_ff[0] <= req_data.vec_x;
                        vel_ff[1] <= req_data.vec_y;
                        vel_ff[2] <= req_data.vec_z;
                        state_ff  <= ST_DONE;
                     end
                     CMD_ADD_ACC: begin
                        acc_ff[0] <= sat32(98'(acc_ff[0]) + 98'(req_data.vec_x));
                        acc_ff[1] <= sat32(98'(acc_ff[1]) + 98'(req_data.vec_y));
                        acc_ff[2] <= sat32(98'(acc_ff[2]) + 98'(req_data.vec_z));
                        state_ff  <= ST_DONE;
                     end
                     CMD_INTEGRATE: state_ff <= ST_INT_MUL;
                     CMD_COLLIDE: begin
                        for (int k = 0; k < 3; k++)
                           d_ff[k] <= 34'(ovec(req_data, 2'(k))) - 34'(pos_ff[k]);
                        d2_ff    <= '0;
                        state_ff <= ST_COL_D;
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_INT_MUL: state_ff <= ST_INT_WAIT;
            ST_INT_WAIT: if (mrsp.done) begin
               // idx 0..2 v*dt, 3..5 a*dt, 6..8 a*dt^2
               if (idx_ff < 4'd3)
                  tmp_ff[i2] <= sat32(98'(mrsp.p >>> DT_BITS));
               else if (idx_ff < 4'd6)
                  vel_ff[v3] <= sat32(98'(vel_ff[v3]) + 98'(mrsp.p >>> DT_BITS));
               else begin
                  pos_ff[2'(idx_ff - 4'd6)] <= sat32(98'(pos_ff[2'(idx_ff - 4'd6)])
                     + 98'(tmp_ff[2'(idx_ff - 4'd6)]) + 98'(mrsp.p >>> (2 * DT_BITS)));
                  acc_ff[2'(idx_ff - 4'd6)] <= '0;
               end
               if (idx_ff == 4'd8) state_ff <= ST_DONE;
               else begin
                  idx_ff   <= idx_ff + 4'd1;
                  state_ff <= ST_INT_MUL;
               end
            end
            ST_COL_D: begin
               if (dabs >= 34'(rsum)) state_ff <= ST_DONE;
               else state_ff <= ST_COL_SQ;
            end
            ST_COL_SQ: state_ff <= ST_COL_SQW;
            ST_COL_SQW: if (mrsp.done) begin
               if (65'(d2_ff) + 65'(mrsp.p[63:0]) > 65'hffff_ffff_ffff_ffff)
                  state_ff <= ST_DONE;
               else begin
                  d2_ff <= d2_ff + mrsp.p[63:0];
                  if (idx_ff == 4'd2) begin
                     state_ff <= ST_COL_LEN;
                     idx_ff   <= '0;
                  end else begin
                     idx_ff   <= idx_ff + 4'd1;
                     state_ff <= ST_COL_D;
                  end
               end
            end
            ST_COL_LEN: begin
               if (d2_ff >= 64'(rsum) * 64'(rsum)) state_ff <= ST_DONE;
               else state_ff <= ST_COL_LENW;
            end
            ST_COL_LENW: if (drsp.done) begin
               len_ff <= drsp.q;
               hit_ff <= 1'b1;
               if (drsp.q == '0) begin
                  dir_ff[0] <= 32'sd1 <<< DIR_BITS;
                  dir_ff[1] <= '0;
                  dir_ff[2] <= '0;
                  state_ff  <= ST_COL_PEN;
               end else state_ff <= ST_COL_DIR;
            end
            ST_COL_DIR: state_ff <= ST_COL_DIRW;
            ST_COL_DIRW: if (drsp.done) begin
               // normal points toward this body: sign opposite to d
               dir_ff[i2] <= d_ff[i2][33] ? drsp.q[31:0] : -drsp.q[31:0];
               if (idx_ff == 4'd2) begin
                  idx_ff   <= '0;
                  state_ff <= ST_COL_PEN;
               end else begin
                  idx_ff   <= idx_ff + 4'd1;
                  state_ff <= ST_COL_DIR;
               end
            end
            ST_COL_PEN: state_ff <= ST_COL_PENW;
            ST_COL_PENW: if (mrsp.done) begin
               pos_ff[i2] <= sat32(98'(pos_ff[i2]) + 98'(mrsp.p >>> DIR_BITS));
               if (idx_ff == 4'd2) begin
                  idx_ff   <= '0;
                  root_ff[0] <= '0;
                  root_ff[1] <= '0;
                  state_ff <= ST_COL_MAG;
               end else begin
                  idx_ff   <= idx_ff + 4'd1;
                  state_ff <= ST_COL_PEN;
               end
            end
            ST_COL_MAG: state_ff <= ST_COL_MAGW;
            ST_COL_MAGW: if (mrsp.done) begin
               root_ff[idx_ff >= 4'd3] <= root_ff[idx_ff >= 4'd3] + mrsp.p[63:0];
               if (idx_ff == 4'd5) begin
                  idx_ff   <= '0;
                  state_ff <= ST_COL_RT;
               end else begin
                  idx_ff   <= idx_ff + 4'd1;
                  state_ff <= ST_COL_MAG;
               end
            end
            ST_COL_RT: state_ff <= ST_COL_RTW;
            ST_COL_RTW: if (drsp.done) begin
               root_ff[idx_ff[0]] <= drsp.q;
               if (idx_ff == 4'd1) begin
                  idx_ff <= '0;
                  if (msum == '0) begin
                     fa_ff    <= '0;
                     fb_ff    <= '0;
                     state_ff <= ST_COL_K;
                  end else state_ff <= ST_COL_FR;
               end else begin
                  idx_ff   <= idx_ff + 4'd1;
                  state_ff <= ST_COL_RT;
               end
            end
            ST_COL_FR: state_ff <= ST_COL_FRW;
            ST_COL_FRW: if (drsp.done) begin
               if (idx_ff[0]) begin
                  fb_ff    <= drsp.q[31:0];
                  idx_ff   <= '0;
                  state_ff <= ST_COL_K;
               end else begin
                  fa_ff    <= drsp.q[31:0];
                  idx_ff   <= 4'd1;
                  state_ff <= ST_COL_FR;
               end
            end
            ST_COL_K: state_ff <= ST_COL_KW;
            ST_COL_KW: if (mrsp.done) begin
               k_ff[idx_ff[0]] <= mrsp.p;
               if (idx_ff[0]) begin
                  idx_ff   <= '0;
                  state_ff <= ST_COL_V;
               end else begin
                  idx_ff   <= 4'd1;
                  state_ff <= ST_COL_K;
               end
            end
            ST_COL_V: state_ff <= ST_COL_VW;
            ST_COL_VW: if (mrsp.done) begin
               if (idx_ff < 4'd3)
                  vel_ff[i2] <= sat32(98'(vel_ff[i2]) + 98'(mrsp.p >>> DIR_BITS));
               else
                  odv_ff[v3] <= sat32(98'(-(mrsp.p)) >>> DIR_BITS);
               if (idx_ff == 4'd5) state_ff <= ST_DONE;
               else begin
                  idx_ff   <= idx_ff + 4'd1;
                  state_ff <= ST_COL_V;
               end
            end
            ST_DONE: begin
               out_ff.pos_x      <= pos_ff[0];
               out_ff.pos_y      <= pos_ff[1];
               out_ff.pos_z      <= pos_ff[2];
               out_ff.vel_x      <= vel_ff[0];
               out_ff.vel_y      <= vel_ff[1];
               out_ff.vel_z      <= vel_ff[2];
               out_ff.hit        <= hit_ff;
               out_ff.other_dv_x <= odv_ff[0];
               out_ff.other_dv_y <= odv_ff[1];
               out_ff.other_dv_z <= odv_ff[2];
               out_valid_ff      <= 1'b1;
               state_ff          <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
